[rtl/core/ray_segment_intersection_macros.svh]
// Assertion macros for the ray/segment intersection block.
// Used by the checker; expects clk_i and rst_ni in the enclosing scope.
`ifndef RAY_SEGMENT_INTERSECTION_MACROS_SVH
`define RAY_SEGMENT_INTERSECTION_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RSI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ray_segment_intersection check failed");

// Next-cycle implication, disabled while in reset
`define RSI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ray_segment_intersection check failed");

`endif

[rtl/core/rsi_pkg.sv]
// Shared types, constants and helpers of the ray/segment intersection block.
// No dependencies.
`timescale 1ns / 1ps

package rsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int EPS_W     = 16;
  localparam int PW        = 2 * DW;
  localparam int QW        = FRAC_BITS + 1;
  localparam int TW        = QW + 1;
  localparam int EDW       = EPS_W + DW;
  localparam int MW        = TW + DW;
  localparam int ADDR_W    = 3;
  localparam int NF        = 5;
  localparam int NB        = 5;
  localparam int NST       = NF + FRAC_BITS + NB;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
  // Register index of epsilon (paddr word index)
  localparam logic [ADDR_W-3:0] REG_EPSILON = '0;

  localparam logic signed [DW+2:0] SAT_MAX = {{4{1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [DW+2:0] SAT_MIN = {{4{1'b1}}, {(DW-1){1'b0}}};

  // Payload carried through the divider stages
  typedef struct packed {
    logic                   miss;
    logic                   neg;
    logic [PW-1:0]          mden;
    logic [PW-1:0]          rem;
    logic [QW-1:0]          quo;
    logic signed [DW-1:0]   ox;
    logic signed [DW-1:0]   oy;
    logic signed [DW-1:0]   sx;
    logic signed [DW-1:0]   sy;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic                   use_x;
    logic                   dir_neg;
    logic [EDW-1:0]         eps_dir;
  } div_t;

  // Saturate a widened value to the signed DW-bit range
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW+2:0] v);
    if (v > SAT_MAX) return SAT_MAX[DW-1:0];
    else if (v < SAT_MIN) return SAT_MIN[DW-1:0];
    else return v[DW-1:0];
  endfunction

endpackage

[rtl/core/rsi_front.sv]
// Front stages: differences, cross products, denominator checks, integer bit.
// Depends on rsi_pkg.
`timescale 1ns / 1ps

module rsi_front import rsi_pkg::*; (
  input  logic                 clk_i,
  input  logic [NF-1:0]        en_i,
  input  logic [EPS_W-1:0]     eps_i,
  input  logic signed [DW-1:0] ray_origin_x_i,
  input  logic signed [DW-1:0] ray_origin_y_i,
  input  logic signed [DW-1:0] ray_dir_x_i,
  input  logic signed [DW-1:0] ray_dir_y_i,
  input  logic signed [DW-1:0] seg_start_x_i,
  input  logic signed [DW-1:0] seg_start_y_i,
  input  logic signed [DW-1:0] seg_end_x_i,
  input  logic signed [DW-1:0] seg_end_y_i,
  output div_t                 res_o
);

  logic signed [DW:0]   eps_s;
  logic signed [DW:0]   ax_mag, ay_mag;
  logic                 ax_big, ay_big;

  // Stage 1 registers
  logic signed [DW-1:0] ox1_q, oy1_q, sx1_q, sy1_q, dx1_q, dy1_q, rx1_q, ry1_q, ax1_q, ay1_q;
  logic                 use_x1_q, dir_neg1_q, dir_bad1_q;
  logic [DW-1:0]        dir_mag1_q;
  // Stage 2 registers
  logic signed [PW-1:0] pa2_q, pb2_q, pc2_q, pd2_q;
  logic signed [DW-1:0] ox2_q, oy2_q, sx2_q, sy2_q, dx2_q, dy2_q;
  logic                 use_x2_q, dir_neg2_q, dir_bad2_q;
  logic [EDW-1:0]       eps_dir2_q;
  // Stage 3 registers
  logic signed [PW-1:0] den3_q, num3_q;
  logic signed [DW-1:0] ox3_q, oy3_q, sx3_q, sy3_q, dx3_q, dy3_q;
  logic                 use_x3_q, dir_neg3_q, dir_bad3_q;
  logic [EDW-1:0]       eps_dir3_q;
  // Stage 4 registers
  logic [PW-1:0]        mden4_q, mnum4_q;
  logic                 neg4_q;
  logic signed [DW-1:0] ox4_q, oy4_q, sx4_q, sy4_q, dx4_q, dy4_q;
  logic                 use_x4_q, dir_neg4_q, dir_bad4_q;
  logic [EDW-1:0]       eps_dir4_q;
  // Stage 5
  logic [PW-1:0]        lim;
  logic                 big, ibit;
  div_t                 res_d, res_q;

  // Direction magnitudes against epsilon
  always_comb begin
    eps_s  = $signed({{(DW+1-EPS_W){1'b0}}, eps_i});
    ax_mag = (DW+1)'(ray_dir_x_i);
    ay_mag = (DW+1)'(ray_dir_y_i);
    if (ax_mag < 0) ax_mag = -ax_mag;
    if (ay_mag < 0) ay_mag = -ay_mag;
    ax_big = ax_mag > eps_s;
    ay_big = ay_mag > eps_s;
  end

  // Stage 1: saturated differences, axis is x if |dir x| > epsilon, else y
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ox1_q      <= ray_origin_x_i;
      oy1_q      <= ray_origin_y_i;
      ax1_q      <= ray_dir_x_i;
      ay1_q      <= ray_dir_y_i;
      sx1_q      <= seg_start_x_i;
      sy1_q      <= seg_start_y_i;
      dx1_q      <= sat_dw((DW+3)'(seg_end_x_i) - (DW+3)'(seg_start_x_i));
      dy1_q      <= sat_dw((DW+3)'(seg_end_y_i) - (DW+3)'(seg_start_y_i));
      rx1_q      <= sat_dw((DW+3)'(seg_start_x_i) - (DW+3)'(ray_origin_x_i));
      ry1_q      <= sat_dw((DW+3)'(seg_start_y_i) - (DW+3)'(ray_origin_y_i));
      use_x1_q   <= ax_big;
      dir_neg1_q <= ax_big ? ray_dir_x_i[DW-1] : ray_dir_y_i[DW-1];
      dir_mag1_q <= ax_big ? ax_mag[DW-1:0] : ay_mag[DW-1:0];
      dir_bad1_q <= !ax_big && !ay_big;
    end
  end

  // Stage 2: cross products and scaled direction tolerance
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pa2_q      <= ay1_q * dx1_q;
      pb2_q      <= ax1_q * dy1_q;
      pc2_q      <= ax1_q * ry1_q;
      pd2_q      <= ay1_q * rx1_q;
      eps_dir2_q <= eps_i * dir_mag1_q;
      ox2_q      <= ox1_q;
      oy2_q      <= oy1_q;
      sx2_q      <= sx1_q;
      sy2_q      <= sy1_q;
      dx2_q      <= dx1_q;
      dy2_q      <= dy1_q;
      use_x2_q   <= use_x1_q;
      dir_neg2_q <= dir_neg1_q;
      dir_bad2_q <= dir_bad1_q;
    end
  end

  // Stage 3: denominator and numerator
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      den3_q     <= pa2_q - pb2_q;
      num3_q     <= pc2_q - pd2_q;
      eps_dir3_q <= eps_dir2_q;
      ox3_q      <= ox2_q;
      oy3_q      <= oy2_q;
      sx3_q      <= sx2_q;
      sy3_q      <= sy2_q;
      dx3_q      <= dx2_q;
      dy3_q      <= dy2_q;
      use_x3_q   <= use_x2_q;
      dir_neg3_q <= dir_neg2_q;
      dir_bad3_q <= dir_bad2_q;
    end
  end

  // Stage 4: magnitudes and quotient sign
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      mden4_q    <= den3_q[PW-1] ? PW'(-den3_q) : PW'(den3_q);
      mnum4_q    <= num3_q[PW-1] ? PW'(-num3_q) : PW'(num3_q);
      neg4_q     <= den3_q[PW-1] ^ num3_q[PW-1];
      eps_dir4_q <= eps_dir3_q;
      ox4_q      <= ox3_q;
      oy4_q      <= oy3_q;
      sx4_q      <= sx3_q;
      sy4_q      <= sy3_q;
      dx4_q      <= dx3_q;
      dy4_q      <= dy3_q;
      use_x4_q   <= use_x3_q;
      dir_neg4_q <= dir_neg3_q;
      dir_bad4_q <= dir_bad3_q;
    end
  end

  // Stage 5: parallel test, early reject of |t1| >= 2, integer quotient bit
  always_comb begin
    lim   = PW'({eps_i, {FRAC_BITS{1'b0}}});
    big   = {1'b0, mnum4_q} >= {mden4_q, 1'b0};
    ibit  = mnum4_q >= mden4_q;
    res_d.miss    = dir_bad4_q || (mden4_q == '0) || (mden4_q < lim) || big;
    res_d.neg     = neg4_q;
    res_d.mden    = mden4_q;
    res_d.rem     = ibit ? (mnum4_q - mden4_q) : mnum4_q;
    res_d.quo     = QW'(ibit);
    res_d.ox      = ox4_q;
    res_d.oy      = oy4_q;
    res_d.sx      = sx4_q;
    res_d.sy      = sy4_q;
    res_d.dx      = dx4_q;
    res_d.dy      = dy4_q;
    res_d.use_x   = use_x4_q;
    res_d.dir_neg = dir_neg4_q;
    res_d.eps_dir = eps_dir4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[rtl/core/rsi_div_step.sv]
// One restoring-division step: one fraction bit of the segment parameter.
// Depends on rsi_pkg.
`timescale 1ns / 1ps

module rsi_div_step import rsi_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t d_i,
  output div_t d_o
);

  logic [PW:0] r2;
  logic        take;
  div_t        d_d, d_q;

  // Shift the remainder, subtract the divisor when it fits
  always_comb begin
    r2   = {d_i.rem, 1'b0};
    take = r2 >= {1'b0, d_i.mden};
    d_d      = d_i;
    d_d.rem  = take ? PW'(r2 - {1'b0, d_i.mden}) : r2[PW-1:0];
    d_d.quo  = {d_i.quo[QW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign d_o = d_q;

endmodule

[rtl/core/rsi_back.sv]
// Back stages: parameter range test, interpolation, ahead test, result register.
// Depends on rsi_pkg.
`timescale 1ns / 1ps

module rsi_back import rsi_pkg::*; (
  input  logic                 clk_i,
  input  logic [NB-1:0]        en_i,
  input  logic [EPS_W-1:0]     eps_i,
  input  div_t                 d_i,
  output logic                 hit_o,
  output logic signed [DW-1:0] hit_x_o,
  output logic signed [DW-1:0] hit_y_o
);

  localparam int CW = DW + 1;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  logic                 rng_bad;
  logic signed [TW-1:0] t1;
  logic signed [DW+1:0] diff;
  logic                 ahead;

  // Stage 1 registers
  logic signed [TW-1:0] t1_1_q;
  logic                 miss1_q, use_x1_q, dir_neg1_q;
  logic signed [DW-1:0] ox1_q, oy1_q, sx1_q, sy1_q, dx1_q, dy1_q;
  logic [EDW-1:0]       eps_dir1_q;
  // Stage 2 registers
  logic signed [MW-1:0] mx2_q, my2_q;
  logic                 miss2_q, use_x2_q, dir_neg2_q;
  logic signed [DW-1:0] ox2_q, oy2_q, sx2_q, sy2_q;
  logic [EDW-1:0]       eps_dir2_q;
  // Stage 3 registers
  logic signed [DW-1:0] px3_q, py3_q, ox3_q, oy3_q;
  logic                 miss3_q, use_x3_q, dir_neg3_q;
  logic [EDW-1:0]       eps_dir3_q;
  // Stage 4 registers
  logic signed [DW+1:0] diff4_q;
  logic signed [DW-1:0] px4_q, py4_q;
  logic                 miss4_q;
  logic [EDW-1:0]       eps_dir4_q;
  // Output registers
  logic                 hit_q;
  logic signed [DW-1:0] hit_x_q, hit_y_q;

  // Signed parameter and its range test
  always_comb begin
    t1 = $signed({1'b0, d_i.quo});
    if (d_i.neg) t1 = -t1;
    if (d_i.neg) rng_bad = CW'(d_i.quo) > CW'(eps_i);
    else         rng_bad = CW'(d_i.quo) > (ONE_C + CW'(eps_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t1_1_q      <= t1;
      miss1_q     <= d_i.miss || rng_bad;
      use_x1_q    <= d_i.use_x;
      dir_neg1_q  <= d_i.dir_neg;
      ox1_q       <= d_i.ox;
      oy1_q       <= d_i.oy;
      sx1_q       <= d_i.sx;
      sy1_q       <= d_i.sy;
      dx1_q       <= d_i.dx;
      dy1_q       <= d_i.dy;
      eps_dir1_q  <= d_i.eps_dir;
    end
  end

  // Stage 2: scale the segment vector by the parameter
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mx2_q      <= t1_1_q * dx1_q;
      my2_q      <= t1_1_q * dy1_q;
      miss2_q    <= miss1_q;
      use_x2_q   <= use_x1_q;
      dir_neg2_q <= dir_neg1_q;
      ox2_q      <= ox1_q;
      oy2_q      <= oy1_q;
      sx2_q      <= sx1_q;
      sy2_q      <= sy1_q;
      eps_dir2_q <= eps_dir1_q;
    end
  end

  // Stage 3: floor shift, add the start point, saturate
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      px3_q      <= sat_dw((DW+3)'(sx2_q) + (DW+3)'(mx2_q >>> FRAC_BITS));
      py3_q      <= sat_dw((DW+3)'(sy2_q) + (DW+3)'(my2_q >>> FRAC_BITS));
      ox3_q      <= ox2_q;
      oy3_q      <= oy2_q;
      miss3_q    <= miss2_q;
      use_x3_q   <= use_x2_q;
      dir_neg3_q <= dir_neg2_q;
      eps_dir3_q <= eps_dir2_q;
    end
  end

  // Stage 4: signed distance along the chosen axis
  always_comb begin
    diff = use_x3_q ? ((DW+2)'(px3_q) - (DW+2)'(ox3_q))
                    : ((DW+2)'(py3_q) - (DW+2)'(oy3_q));
    if (dir_neg3_q) diff = -diff;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      diff4_q    <= diff;
      px4_q      <= px3_q;
      py4_q      <= py3_q;
      miss4_q    <= miss3_q;
      eps_dir4_q <= eps_dir3_q;
    end
  end

  // Stage 5: cross-multiplied ahead test, zero the point on a miss
  assign ahead = $signed({diff4_q, {FRAC_BITS{1'b0}}}) > $signed({1'b0, eps_dir4_q});

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      hit_q   <= !miss4_q && ahead;
      hit_x_q <= (!miss4_q && ahead) ? px4_q : '0;
      hit_y_q <= (!miss4_q && ahead) ? py4_q : '0;
    end
  end

  assign hit_o   = hit_q;
  assign hit_x_o = hit_x_q;
  assign hit_y_o = hit_y_q;

endmodule

[rtl/core/ray_segment_intersection.sv]
// Ray/segment intersection in signed Q16.16: one transaction per cycle unless
// stalled, through 5 front stages, 16 divider stages that each yield one
// fraction bit of the segment parameter, 5 back stages. An output stall holds
// each full stage whose successor cannot move, so empty stages keep filling.
// Users write epsilon (APB word 0, reset value 1) only when idle; not enforced.
// Depends on rsi_pkg, rsi_front, rsi_div_step, rsi_back.
`timescale 1ns / 1ps

module ray_segment_intersection import rsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // Input transaction
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [DW-1:0] ray_origin_x_i,
  input  logic signed [DW-1:0] ray_origin_y_i,
  input  logic signed [DW-1:0] ray_dir_x_i,
  input  logic signed [DW-1:0] ray_dir_y_i,
  input  logic signed [DW-1:0] seg_start_x_i,
  input  logic signed [DW-1:0] seg_start_y_i,
  input  logic signed [DW-1:0] seg_end_x_i,
  input  logic signed [DW-1:0] seg_end_y_i,
  // Output transaction
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic                 hit_o,
  output logic signed [DW-1:0] hit_x_o,
  output logic signed [DW-1:0] hit_y_o
);

  logic [EPS_W-1:0] eps_q;
  logic [NST-1:0]   vld_q;
  logic [NST-1:0]   en;
  div_t             chain [FRAC_BITS+1];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_EPSILON)) begin
      eps_q <= pwdata[EPS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_EPSILON) ? 32'(eps_q) : '0;

  // Stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    en[NST-1] = !vld_q[NST-1] || !stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign stall_o = !en[0];
  assign valid_o = vld_q[NST-1];

  rsi_front u_front (
    .clk_i          (clk_i),
    .en_i           (en[NF-1:0]),
    .eps_i          (eps_q),
    .ray_origin_x_i (ray_origin_x_i),
    .ray_origin_y_i (ray_origin_y_i),
    .ray_dir_x_i    (ray_dir_x_i),
    .ray_dir_y_i    (ray_dir_y_i),
    .seg_start_x_i  (seg_start_x_i),
    .seg_start_y_i  (seg_start_y_i),
    .seg_end_x_i    (seg_end_x_i),
    .seg_end_y_i    (seg_end_y_i),
    .res_o          (chain[0])
  );

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_div
    rsi_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en[NF+g]),
      .d_i   (chain[g]),
      .d_o   (chain[g+1])
    );
  end

  rsi_back u_back (
    .clk_i   (clk_i),
    .en_i    (en[NST-1:NF+FRAC_BITS]),
    .eps_i   (eps_q),
    .d_i     (chain[FRAC_BITS]),
    .hit_o   (hit_o),
    .hit_x_o (hit_x_o),
    .hit_y_o (hit_y_o)
  );

endmodule

[rtl/core/rsi_checker.sv]
// Port-level checker for ray_segment_intersection, bound to the top level.
// Depends on rsi_pkg and ray_segment_intersection_macros.svh.
`timescale 1ns / 1ps
`include "ray_segment_intersection_macros.svh"

module rsi_checker import rsi_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 stall_o,
  input logic                 valid_o,
  input logic                 stall_i,
  input logic                 hit_o,
  input logic signed [DW-1:0] hit_x_o,
  input logic signed [DW-1:0] hit_y_o
);

  // Hold a stalled result
  `RSI_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o && $stable({hit_o, hit_x_o, hit_y_o}))
  // Zero the point on a miss
  `RSI_ASSERT_IMPL(a_miss_zero, valid_o && !hit_o, hit_x_o == '0 && hit_y_o == '0)
  // Never stall the input while the output stage is empty
  `RSI_ASSERT_IMPL(a_free_when_empty, !valid_o, !stall_o)
  // Never stall the input while the output drains
  `RSI_ASSERT_IMPL(a_free_when_drained, !stall_i, !stall_o)

endmodule

bind ray_segment_intersection rsi_checker u_rsi_checker (.*);
